FILE: rtl/msb_pkg.sv
// shared types, opcodes and sprite row helpers for the mono sprite blitter
// no dependencies; used by msb_align, msb_rowmem and mono_sprite_blitter
package msb_pkg;

    localparam int SPR_W = 24;

    localparam logic [3:0] OP_SET    = 4'd0;
    localparam logic [3:0] OP_GET    = 4'd1;
    localparam logic [3:0] OP_OR     = 4'd2;
    localparam logic [3:0] OP_XOR    = 4'd3;
    localparam logic [3:0] OP_AND    = 4'd4;
    localparam logic [3:0] OP_OVR    = 4'd5;
    localparam logic [3:0] OP_MASK   = 4'd6;
    localparam logic [3:0] OP_CLEAR  = 4'd7;
    localparam logic [3:0] OP_RDBYTE = 4'd8;

    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;

    localparam logic [SPR_W-1:0] LEFT_PIXEL = 24'h80_0000;

    typedef struct packed {
        logic wr_en;
        logic clr_all;
    } mem_ctl_t;

    // ones over the sprite width, leftmost pixel at the msb
    function automatic logic [SPR_W-1:0] width_mask(input logic [1:0] wc);
        logic [SPR_W-1:0] m;
        case (wc)
            WC_8:    m = 24'hFF_0000;
            WC_16:   m = 24'hFFFF_00;
            default: m = 24'hFF_FFFF;
        endcase
        return m;
    endfunction

    // optional mirror, then leftmost pixel moved to the msb, unused bits cleared
    function automatic logic [SPR_W-1:0] norm_row(input logic [SPR_W-1:0] b,
                                                  input logic [1:0] wc,
                                                  input logic flip);
        logic [SPR_W-1:0] r;
        logic [SPR_W-1:0] sh;
        for (int i = 0; i < SPR_W; i++)
        begin
            r[i] = b[SPR_W-1-i];
        end
        case (wc)
            WC_8:    sh = {b[7:0], 16'h0000};
            WC_16:   sh = {b[15:0], 8'h00};
            default: sh = b;
        endcase
        return flip ? (r & width_mask(wc)) : sh;
    endfunction

endpackage

FILE: rtl/mono_sprite_blitter.sv
// Mono sprite blitter: a SCREEN_W x SCREEN_H one-bit framebuffer with pixel set/get,
// sprite row blits (or, xor, and, overwrite, masked), clear and byte read-back.
// A command is taken when start is high and busy is low; busy then stays high in
// S_SPR, S_KEEP and S_AREA while one shared alignment shifter places the sprite, the
// mask and the sprite area in turn; no new command is taken before S_AREA ends.
// The row word is read at the accepting edge and written back in the last busy cycle.
// Every command gives exactly one result beat, shown for a single cycle with done
// high, and the receiver cannot hold it off. Clear takes effect in one command.
// depends on msb_pkg, msb_align, msb_rowmem
module mono_sprite_blitter #(
    parameter int SCREEN_W = 48,
    parameter int SCREEN_H = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [3:0]                       op,
    input  logic signed [7:0]                x,
    input  logic signed [6:0]                y,
    input  logic [1:0]                       row_width,
    input  logic                             hflip,
    input  logic [msb_pkg::SPR_W-1:0]        row_bits,
    input  logic [msb_pkg::SPR_W-1:0]        mask_bits,
    input  logic                             pixel_value,
    output logic                             done,
    output logic                             pixel,
    output logic [7:0]                       byte_value
);

    localparam int AW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
    localparam int NB = (SCREEN_W + 7) / 8;
    localparam int PW = SCREEN_W + 8;
    localparam int BW = $clog2(PW) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SPR  = 2'd1;
    localparam logic [1:0] S_KEEP = 2'd2;
    localparam logic [1:0] S_AREA = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic                        done_reg;
    logic                        accept;
    logic                        y_ok;

    logic [3:0]                  op_reg;
    logic signed [7:0]           x_reg;
    logic                        yok_reg;
    logic [AW-1:0]               addr_reg;
    logic                        pv_reg;
    logic [msb_pkg::SPR_W-1:0]   spr_src_reg;
    logic [msb_pkg::SPR_W-1:0]   msk_src_reg;
    logic [msb_pkg::SPR_W-1:0]   area_src_reg;
    logic [SCREEN_W-1:0]         spr_reg;
    logic [SCREEN_W-1:0]         keep_reg;
    logic                        pixel_reg;
    logic                        pixel_next;
    logic [7:0]                  byte_reg;
    logic [7:0]                  byte_next;

    logic [msb_pkg::SPR_W-1:0]   unit_in;
    logic [SCREEN_W-1:0]         unit_out;
    logic [SCREEN_W-1:0]         row;
    logic [SCREEN_W-1:0]         area;
    logic [SCREEN_W-1:0]         row_new;
    logic                        row_wr;
    msb_pkg::mem_ctl_t           mem_ctl;
    logic [PW-1:0]               padded;
    logic [PW-1:0]               padded_sh;
    logic [BW-1:0]               byte_amt;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign y_ok   = !y[6] && ({1'b0, y[5:0]} < 7'(SCREEN_H));

    always_comb
    begin
        unique case (state_reg)
            S_IDLE: state_next = accept ? S_SPR : S_IDLE;
            S_SPR:  state_next = S_KEEP;
            S_KEEP: state_next = S_AREA;
            S_AREA: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_AREA);
        end
    end

    // operand for the shared shifter, one per busy cycle
    always_comb
    begin
        unique case (state_reg)
            S_SPR:   unit_in = spr_src_reg;
            S_KEEP:  unit_in = msk_src_reg;
            S_AREA:  unit_in = area_src_reg;
            default: unit_in = spr_src_reg;
        endcase
    end

    msb_align #(
        .SCREEN_W (SCREEN_W)
    ) u_align (
        .opnd    (unit_in),
        .col     (x_reg),
        .aligned (unit_out)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            x_reg       <= x;
            yok_reg     <= y_ok;
            addr_reg    <= y[AW-1:0];
            pv_reg      <= pixel_value;
            spr_src_reg <= msb_pkg::norm_row(row_bits, row_width, hflip);
            msk_src_reg <= msb_pkg::norm_row(mask_bits, row_width, hflip);
            if ((op == msb_pkg::OP_SET) || (op == msb_pkg::OP_GET))
            begin
                area_src_reg <= msb_pkg::LEFT_PIXEL;
            end
            else
            begin
                area_src_reg <= msb_pkg::width_mask(row_width);
            end
        end
        if (state_reg == S_SPR)
        begin
            spr_reg <= unit_out;
        end
        if (state_reg == S_KEEP)
        begin
            keep_reg <= unit_out;
        end
        if (state_reg == S_AREA)
        begin
            pixel_reg <= pixel_next;
            byte_reg  <= byte_next;
        end
    end

    assign area = unit_out;

    always_comb
    begin
        case (op_reg)
            msb_pkg::OP_SET:  row_new = pv_reg ? (row | area) : (row & ~area);
            msb_pkg::OP_OR:   row_new = row | spr_reg;
            msb_pkg::OP_XOR:  row_new = row ^ spr_reg;
            msb_pkg::OP_AND:  row_new = row & (~area | spr_reg);
            msb_pkg::OP_OVR:  row_new = (row & ~area) | spr_reg;
            msb_pkg::OP_MASK: row_new = (row & (~area | keep_reg)) | spr_reg;
            default:          row_new = row;
        endcase
        case (op_reg) inside
            msb_pkg::OP_SET, msb_pkg::OP_OR, msb_pkg::OP_XOR, msb_pkg::OP_AND,
            msb_pkg::OP_OVR, msb_pkg::OP_MASK: row_wr = yok_reg;
            default:                           row_wr = 1'b0;
        endcase
    end

    assign mem_ctl.wr_en   = (state_reg == S_AREA) && row_wr;
    assign mem_ctl.clr_all = (state_reg == S_AREA) && (op_reg == msb_pkg::OP_CLEAR);

    msb_rowmem #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H),
        .AW       (AW)
    ) u_rowmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && y_ok),
        .rd_addr (y[AW-1:0]),
        .ctl     (mem_ctl),
        .wr_addr (addr_reg),
        .wr_data (row_new),
        .rd_data (row)
    );

    // byte read-back, columns past the right edge read as zero
    assign padded    = {row, 8'h00};
    assign byte_amt  = BW'(SCREEN_W) - BW'({x_reg[2:0], 3'b000});
    assign padded_sh = padded >> byte_amt;

    assign pixel_next = (op_reg == msb_pkg::OP_GET) && yok_reg && (|(row & area));
    assign byte_next  = ((op_reg == msb_pkg::OP_RDBYTE) && yok_reg && !x_reg[7]
                        && (x_reg[6:0] < 7'(NB))) ? padded_sh[7:0] : 8'h00;

    assign done       = done_reg;
    assign pixel      = pixel_reg;
    assign byte_value = byte_reg;

endmodule

FILE: rtl/msb_align.sv
// shared alignment shifter: places a 24-pixel operand at a signed pixel column
// of a screen row word, dropping columns off either edge; uses msb_pkg
module msb_align #(
    parameter int SCREEN_W = 48
) (
    input  logic [msb_pkg::SPR_W-1:0] opnd,
    input  logic signed [7:0]         col,
    output logic [SCREEN_W-1:0]       aligned
);

    localparam int WIDE_W = SCREEN_W + msb_pkg::SPR_W;

    logic signed [8:0]  pos;
    logic               in_range;
    logic [WIDE_W-1:0]  wide;
    logic [WIDE_W-1:0]  shifted;

    assign pos      = {col[7], col} + 9'sd24;
    assign in_range = !pos[8] && (pos[7:0] < 8'(WIDE_W));
    assign wide     = {opnd, {SCREEN_W{1'b0}}};
    assign shifted  = wide >> pos[7:0];
    assign aligned  = in_range ? shifted[SCREEN_W-1:0] : '0;

endmodule

FILE: rtl/msb_rowmem.sv
// framebuffer row store: one row word per entry, registered read port,
// per-row valid bits so reset and clear take effect at once; uses msb_pkg
module msb_rowmem #(
    parameter int SCREEN_W = 48,
    parameter int SCREEN_H = 32,
    parameter int AW       = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    input  msb_pkg::mem_ctl_t     ctl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [SCREEN_W-1:0]   wr_data,
    output logic [SCREEN_W-1:0]   rd_data
);

    logic [SCREEN_W-1:0] mem [SCREEN_H];
    logic [SCREEN_H-1:0] valid_reg;
    logic [SCREEN_W-1:0] data_reg;
    logic                vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = vld_reg ? data_reg : '0;

endmodule
